FILE: design/irt_pkg.sv
// ----------------------------------------------------------------------------
// irt_pkg: shared types and codes for the interval reservation table
// Result status codes and the command/status bundles between the controller
// and the datapath.
// ----------------------------------------------------------------------------
package irt_pkg;

  localparam logic [1:0] STATUS_GRANTED   = 2'd0;
  localparam logic [1:0] STATUS_OVERLAP   = 2'd1;
  localparam logic [1:0] STATUS_FULL      = 2'd2;
  localparam logic [1:0] STATUS_MALFORMED = 2'd3;

  typedef struct packed {
    logic load;
    logic scan;
    logic write;
  } irt_cmd_t;

  typedef struct packed {
    logic malformed;
    logic scan_done;
    logic hit;
    logic full;
  } irt_stat_t;

endpackage

FILE: design/interval_reservation_table.sv
// ----------------------------------------------------------------------------
// interval_reservation_table: closed address range reservation table
// Grants a requested range when its start does not exceed its end, it overlaps
// no stored range and the table has room, and records it.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Its status appears on
// out_status with out_valid high for one cycle. A request whose start exceeds
// its end is answered after the check, with no scan; any other is answered once
// the scan has compared it with every stored range. The scan reads the table
// memory one entry per cycle, and that read port sets the latency. busy falls as
// the result shows, so the next request may be taken in that same cycle. The
// receiver cannot hold a result off: sample it while out_valid is high.
module interval_reservation_table #(
  parameter int MAX_RANGES = 64,
  parameter int ADDR_BITS  = 31
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [ADDR_BITS-1:0] in_range_start,
  input  logic [ADDR_BITS-1:0] in_range_end,
  output logic                 out_valid,
  output logic [1:0]           out_status
);

  irt_pkg::irt_cmd_t  cmd;
  irt_pkg::irt_stat_t stat;

  irt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .stat       (stat),
    .cmd        (cmd),
    .busy       (busy),
    .out_valid  (out_valid),
    .out_status (out_status)
  );

  irt_dp #(
    .MAX_RANGES (MAX_RANGES),
    .ADDR_BITS  (ADDR_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_range_start (in_range_start),
    .in_range_end   (in_range_end),
    .stat           (stat)
  );

endmodule

FILE: design/irt_dp.sv
// ----------------------------------------------------------------------------
// irt_dp: range table datapath
// Holds the request, the stored start and end memories, the entry count and
// the scan pointer; compares one stored range per cycle against the request.
// ----------------------------------------------------------------------------
module irt_dp #(
  parameter int MAX_RANGES = 64,
  parameter int ADDR_BITS  = 31
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  irt_pkg::irt_cmd_t    cmd,
  input  logic [ADDR_BITS-1:0] in_range_start,
  input  logic [ADDR_BITS-1:0] in_range_end,
  output irt_pkg::irt_stat_t   stat
);

  localparam int IDX_W = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
  localparam int CNT_W = $clog2(MAX_RANGES + 1);

  logic [ADDR_BITS-1:0] mem_start [MAX_RANGES];
  logic [ADDR_BITS-1:0] mem_end   [MAX_RANGES];

  logic [ADDR_BITS-1:0] lo_r;
  logic [ADDR_BITS-1:0] hi_r;
  logic [ADDR_BITS-1:0] rd_start_r;
  logic [ADDR_BITS-1:0] rd_end_r;
  logic [CNT_W-1:0]     count_r;
  logic [CNT_W-1:0]     rd_idx_r;
  logic                 cmp_vld_r;
  logic                 hit_r;
  logic                 issue;
  logic                 overlap;

  assign issue   = cmd.scan && (rd_idx_r != count_r);
  assign overlap = (lo_r <= rd_end_r) && (rd_start_r <= hi_r);

  // request capture and scan control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      rd_idx_r  <= '0;
      cmp_vld_r <= 1'b0;
      hit_r     <= 1'b0;
    end else begin
      if (cmd.load) begin
        lo_r      <= in_range_start;
        hi_r      <= in_range_end;
        rd_idx_r  <= '0;
        cmp_vld_r <= 1'b0;
        hit_r     <= 1'b0;
      end else if (cmd.scan) begin
        cmp_vld_r <= issue;
        if (issue) begin
          rd_idx_r <= rd_idx_r + CNT_W'(1);
        end
        if (cmp_vld_r && overlap) begin
          hit_r <= 1'b1;
        end
      end
      if (cmd.write) begin
        count_r <= count_r + CNT_W'(1);
      end
    end
  end

  // table memories
  always_ff @(posedge clk) begin
    if (cmd.write) begin
      mem_start[count_r[IDX_W-1:0]] <= lo_r;
      mem_end[count_r[IDX_W-1:0]]   <= hi_r;
    end
    if (issue) begin
      rd_start_r <= mem_start[rd_idx_r[IDX_W-1:0]];
      rd_end_r   <= mem_end[rd_idx_r[IDX_W-1:0]];
    end
  end

  assign stat.malformed = (lo_r > hi_r);
  assign stat.scan_done = (rd_idx_r == count_r) && !cmp_vld_r;
  assign stat.hit       = hit_r;
  assign stat.full      = (count_r == CNT_W'(MAX_RANGES));

endmodule

FILE: design/irt_ctrl.sv
// ----------------------------------------------------------------------------
// irt_ctrl: request controller
// Sequences capture, table scan and decision, and registers the result
// status and its strobe.
// ----------------------------------------------------------------------------
module irt_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  irt_pkg::irt_stat_t stat,
  output irt_pkg::irt_cmd_t  cmd,
  output logic               busy,
  output logic               out_valid,
  output logic [1:0]         out_status
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CHECK = 2'd1;
  localparam logic [1:0] S_SCAN  = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic       valid_r;
  logic       valid_nxt;
  logic [1:0] status_r;
  logic [1:0] status_nxt;

  always_comb begin
    state_nxt  = state_r;
    valid_nxt  = 1'b0;
    status_nxt = status_r;
    cmd        = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.malformed) begin
          valid_nxt  = 1'b1;
          status_nxt = irt_pkg::STATUS_MALFORMED;
          state_nxt  = S_IDLE;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_done) begin
          valid_nxt = 1'b1;
          state_nxt = S_IDLE;
          if (stat.hit) begin
            status_nxt = irt_pkg::STATUS_OVERLAP;
          end else if (stat.full) begin
            status_nxt = irt_pkg::STATUS_FULL;
          end else begin
            status_nxt = irt_pkg::STATUS_GRANTED;
            cmd.write  = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
  end

  assign busy       = (state_r != S_IDLE);
  assign out_valid  = valid_r;
  assign out_status = status_r;

endmodule

FILE: design/irt_checker.sv
// ----------------------------------------------------------------------------
// irt_checker: port-level checks for the interval reservation table
// Watches the request handshake, the result strobe and the reversed-range status.
// ----------------------------------------------------------------------------
module irt_checker #(
  parameter int ADDR_BITS = 31
) (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 start,
  input logic                 busy,
  input logic [ADDR_BITS-1:0] in_range_start,
  input logic [ADDR_BITS-1:0] in_range_end,
  input logic                 out_valid,
  input logic [1:0]           out_status
);

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("request taken without raising busy");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while busy");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  a_done_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("request finished without a result");

  a_malformed: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_range_start > in_range_end)
      |-> ##2 (out_valid && (out_status == irt_pkg::STATUS_MALFORMED)))
    else $error("reversed range not flagged");

endmodule

bind interval_reservation_table irt_checker #(
  .ADDR_BITS (ADDR_BITS)
) u_irt_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .in_range_start (in_range_start),
  .in_range_end   (in_range_end),
  .out_valid      (out_valid),
  .out_status     (out_status)
);
